[rtl/utf8_stream_validator_core_assert.svh]
// assertion macros for the utf8 stream validator
`ifndef UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_CORE_ASSERT_SVH

// condition must hold whenever out of reset
`define UTF8SV_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("utf8sv invariant violated");

// consequent must hold in the cycle after the antecedent
`define UTF8SV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8sv sequence check failed");

`endif

[rtl/utf8sv_pkg.sv]
`default_nettype none

package utf8sv_pkg;

  // allowed range of the first continuation byte
  typedef enum logic [2:0] {
    CLS_FULL = 3'd0,
    CLS_A0BF = 3'd1,
    CLS_809F = 3'd2,
    CLS_90BF = 3'd3,
    CLS_808F = 3'd4
  } cls_t;

  typedef struct packed {
    logic [1:0] bytes_pending;
    cls_t       second_byte_class;
    logic       at_second_byte;
    logic       seen_error;
    logic       seen_non_ascii;
    logic       stopped_at_zero;
  } state_t;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_8F    = 8'h8F;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] CONT_9F    = 8'h9F;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_E0   = 8'hE0;
  localparam logic [7:0] LEAD3_LO   = 8'hE1;
  localparam logic [7:0] LEAD3_ED   = 8'hED;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_F0   = 8'hF0;
  localparam logic [7:0] LEAD4_LO   = 8'hF1;
  localparam logic [7:0] LEAD4_HI   = 8'hF3;
  localparam logic [7:0] LEAD4_F4   = 8'hF4;

endpackage

`default_nettype wire

[rtl/utf8sv_if.sv]
`default_nettype none

interface utf8sv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface utf8sv_out_if;
  logic valid;
  logic ready;
  logic well_formed;
  logic pure_ascii;

  modport source (output valid, output well_formed, output pure_ascii, input ready);
  modport sink (input valid, input well_formed, input pure_ascii, output ready);
endinterface

`default_nettype wire

[rtl/utf8_stream_validator_core.sv]
// a final byte is held in the input register; its result is then registered in the output register
// throughput: one byte per cycle, limited by the per-byte state register update
// the input register stalls only while a final-byte result waits on a full output register
// reset: synchronous active-low rst_n clears the sequence state and all valid flags
`default_nettype none

module utf8_stream_validator_core (
  input wire logic     clk,
  input wire logic     rst_n,
  utf8sv_in_if.sink    in_chan,
  utf8sv_out_if.source out_chan
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  utf8sv_pkg::state_t st_r;
  utf8sv_pkg::state_t st_step;
  logic               out_valid_r;
  logic               out_well_formed_r;
  logic               out_pure_ascii_r;
  logic               s1_fire;
  logic               ok_nxt;

  assign s1_fire       = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  utf8sv_byte_step u_step (
    .data_byte (s1_byte_r),
    .st_cur    (st_r),
    .st_nxt    (st_step)
  );

  assign ok_nxt = !st_step.seen_error &&
                  (st_step.stopped_at_zero || st_step.bytes_pending == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_fire) begin
        st_r <= s1_last_r ? utf8sv_pkg::state_t'('0) : st_step;
      end
      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.end_of_message;
    end
    if (s1_fire && s1_last_r) begin
      out_well_formed_r <= ok_nxt;
      out_pure_ascii_r  <= ok_nxt && !st_step.seen_non_ascii;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.well_formed = out_well_formed_r;
  assign out_chan.pure_ascii  = out_pure_ascii_r;

`include "utf8_stream_validator_core_assert.svh"

  `UTF8SV_ASSERT_ALWAYS(a_second_needs_pending, !st_r.at_second_byte || st_r.bytes_pending != 2'd0)
  `UTF8SV_ASSERT_ALWAYS(a_ascii_implies_valid, !out_valid_r || !out_pure_ascii_r || out_well_formed_r)
  `UTF8SV_ASSERT_NEXT(a_last_clears_state, s1_fire && s1_last_r, st_r == utf8sv_pkg::state_t'('0))
  `UTF8SV_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_last_r, out_valid_r)

endmodule

`default_nettype wire

[rtl/utf8sv_byte_step.sv]
`default_nettype none

module utf8sv_byte_step (
  input  wire logic [7:0]        data_byte,
  input  wire utf8sv_pkg::state_t st_cur,
  output utf8sv_pkg::state_t     st_nxt
);

  logic              cont_ok;
  utf8sv_pkg::cls_t  cls_sel;

  assign cls_sel = st_cur.at_second_byte ? st_cur.second_byte_class : utf8sv_pkg::CLS_FULL;

  always_comb begin
    unique case (cls_sel)
      utf8sv_pkg::CLS_A0BF: cont_ok = data_byte >= utf8sv_pkg::CONT_A0 &&
                                      data_byte <= utf8sv_pkg::CONT_HI;
      utf8sv_pkg::CLS_809F: cont_ok = data_byte >= utf8sv_pkg::CONT_LO &&
                                      data_byte <= utf8sv_pkg::CONT_9F;
      utf8sv_pkg::CLS_90BF: cont_ok = data_byte >= utf8sv_pkg::CONT_90 &&
                                      data_byte <= utf8sv_pkg::CONT_HI;
      utf8sv_pkg::CLS_808F: cont_ok = data_byte >= utf8sv_pkg::CONT_LO &&
                                      data_byte <= utf8sv_pkg::CONT_8F;
      default:              cont_ok = data_byte >= utf8sv_pkg::CONT_LO &&
                                      data_byte <= utf8sv_pkg::CONT_HI;
    endcase
  end

  always_comb begin
    st_nxt = st_cur;
    if (!st_cur.seen_error && !st_cur.stopped_at_zero) begin
      if (st_cur.bytes_pending != 2'd0) begin
        st_nxt.seen_non_ascii = 1'b1;
        if (cont_ok) begin
          st_nxt.bytes_pending  = 2'(st_cur.bytes_pending - 2'd1);
          st_nxt.at_second_byte = 1'b0;
        end else begin
          st_nxt.seen_error = 1'b1;
        end
      end else begin
        unique case (data_byte) inside
          utf8sv_pkg::BYTE_NUL: begin
            st_nxt.stopped_at_zero = 1'b1;
          end
          utf8sv_pkg::BYTE_TAB, utf8sv_pkg::BYTE_LF, utf8sv_pkg::BYTE_CR,
          [utf8sv_pkg::PRINT_LO:utf8sv_pkg::PRINT_HI]: begin
          end
          [utf8sv_pkg::LEAD2_LO:utf8sv_pkg::LEAD2_HI]: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd1;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_FULL;
            st_nxt.at_second_byte    = 1'b1;
          end
          utf8sv_pkg::LEAD3_E0: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd2;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_A0BF;
            st_nxt.at_second_byte    = 1'b1;
          end
          utf8sv_pkg::LEAD3_ED: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd2;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_809F;
            st_nxt.at_second_byte    = 1'b1;
          end
          [utf8sv_pkg::LEAD3_LO:8'hEC], [8'hEE:utf8sv_pkg::LEAD3_HI]: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd2;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_FULL;
            st_nxt.at_second_byte    = 1'b1;
          end
          utf8sv_pkg::LEAD4_F0: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd3;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_90BF;
            st_nxt.at_second_byte    = 1'b1;
          end
          utf8sv_pkg::LEAD4_F4: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd3;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_808F;
            st_nxt.at_second_byte    = 1'b1;
          end
          [utf8sv_pkg::LEAD4_LO:utf8sv_pkg::LEAD4_HI]: begin
            st_nxt.seen_non_ascii    = 1'b1;
            st_nxt.bytes_pending     = 2'd3;
            st_nxt.second_byte_class = utf8sv_pkg::CLS_FULL;
            st_nxt.at_second_byte    = 1'b1;
          end
          default: begin
            // other control bytes, 0x7f, stray continuation, bad leads
            st_nxt.seen_non_ascii = 1'b1;
            st_nxt.seen_error     = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import utf8sv_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    logic well_formed;
    logic pure_ascii;
  } verdict_t;

  logic clk;
  logic rst_n;

  utf8sv_in_if  in_chan ();
  utf8sv_out_if out_chan ();

  utf8_stream_validator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  req_t       bytes_to_send[$];
  verdict_t   verdicts_due[$];
  logic [7:0] msg_bytes[$];
  verdict_t   got;
  int         fail_count;
  int         bytes_taken;
  int         results_seen;
  int         hold_left;

  // predicted decoder state
  logic [1:0] cont_left;
  cls_t       first_cont_range;
  logic       at_first_cont;
  logic       bad_seen;
  logic       wide_seen;
  logic       nul_stop;

  function automatic logic cont_fits(input logic [7:0] b, input cls_t range_sel);
    case (range_sel)
      CLS_A0BF: return b >= CONT_A0 && b <= CONT_HI;
      CLS_809F: return b >= CONT_LO && b <= CONT_9F;
      CLS_90BF: return b >= CONT_90 && b <= CONT_HI;
      CLS_808F: return b >= CONT_LO && b <= CONT_8F;
      default:  return b >= CONT_LO && b <= CONT_HI;
    endcase
  endfunction

  task automatic open_sequence(input logic [1:0] count, input cls_t range_sel);
    cont_left        = count;
    first_cont_range = range_sel;
    at_first_cont    = 1'b1;
  endtask

  task automatic clear_decoder();
    cont_left        = 2'd0;
    first_cont_range = CLS_FULL;
    at_first_cont    = 1'b0;
    bad_seen         = 1'b0;
    wide_seen        = 1'b0;
    nul_stop         = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    if (!bad_seen && !nul_stop) begin
      if (cont_left != 2'd0) begin
        wide_seen = 1'b1;
        if (cont_fits(b, at_first_cont ? first_cont_range : CLS_FULL)) begin
          cont_left     = cont_left - 2'd1;
          at_first_cont = 1'b0;
        end else begin
          bad_seen = 1'b1;
        end
      end else if (b == BYTE_NUL) begin
        nul_stop = 1'b1;
      end else if (!((b >= PRINT_LO && b <= PRINT_HI) || b == BYTE_TAB ||
                     b == BYTE_LF || b == BYTE_CR)) begin
        wide_seen = 1'b1;
        if (b >= LEAD2_LO && b <= LEAD2_HI) open_sequence(2'd1, CLS_FULL);
        else if (b == LEAD3_E0) open_sequence(2'd2, CLS_A0BF);
        else if (b == LEAD3_ED) open_sequence(2'd2, CLS_809F);
        else if (b >= LEAD3_LO && b <= LEAD3_HI) open_sequence(2'd2, CLS_FULL);
        else if (b == LEAD4_F0) open_sequence(2'd3, CLS_90BF);
        else if (b == LEAD4_F4) open_sequence(2'd3, CLS_808F);
        else if (b >= LEAD4_LO && b <= LEAD4_HI) open_sequence(2'd3, CLS_FULL);
        else bad_seen = 1'b1;
      end
    end
    if (last) begin
      v.well_formed = !bad_seen && (nul_stop || cont_left == 2'd0);
      v.pure_ascii  = v.well_formed && !wide_seen;
      verdicts_due.push_back(v);
      clear_decoder();
    end
  endtask

  task automatic queue_message();
    req_t r;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      r.data = msg_bytes[i];
      r.last = (i == msg_bytes.size() - 1);
      bytes_to_send.push_back(r);
    end
  endtask

  task automatic random_messages(input int target);
    int count;
    int n;
    int kind;
    int pos;
    logic [7:0] v;
    count = 0;
    while (count < target) begin
      msg_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          kind = $urandom_range(0, 9);
          if (kind < 5) begin
            case ($urandom_range(0, 9))
              0: msg_bytes.push_back(BYTE_TAB);
              1: msg_bytes.push_back(BYTE_LF);
              2: msg_bytes.push_back(BYTE_CR);
              default: msg_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
            endcase
          end else if (kind == 5) begin
            msg_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
          end else if (kind < 8) begin
            v = 8'($urandom_range(LEAD3_E0, LEAD3_HI));
            msg_bytes.push_back(v);
            if (v == LEAD3_E0) msg_bytes.push_back(8'($urandom_range(CONT_A0, CONT_HI)));
            else if (v == LEAD3_ED) msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_9F)));
            else msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
          end else begin
            v = 8'($urandom_range(LEAD4_F0, LEAD4_F4));
            msg_bytes.push_back(v);
            if (v == LEAD4_F0) msg_bytes.push_back(8'($urandom_range(CONT_90, CONT_HI)));
            else if (v == LEAD4_F4) msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_8F)));
            else msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            msg_bytes.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
          end
        end
        // damage some messages
        if ($urandom_range(0, 99) < 30) begin
          pos = $urandom_range(0, msg_bytes.size() - 1);
          case ($urandom_range(0, 3))
            0: msg_bytes[pos] = 8'($urandom_range(0, 255));
            1: begin
              if (msg_bytes.size() > 1) msg_bytes.delete(msg_bytes.size() - 1);
              else msg_bytes[pos] = CONT_LO;
            end
            2: msg_bytes.insert(pos, BYTE_NUL);
            default: begin
              case ($urandom_range(0, 2))
                0: msg_bytes[pos] = 8'($urandom_range(1, 31));
                1: msg_bytes[pos] = 8'($urandom_range(8'h7F, 8'hC1));
                default: msg_bytes[pos] = 8'($urandom_range(8'hF5, 8'hFF));
              endcase
            end
          endcase
        end
      end
      queue_message();
      count += msg_bytes.size();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || verdicts_due.size() != 0 || in_chan.valid);
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.data_byte      = 8'h00;
    in_chan.end_of_message = 1'b0;
    out_chan.ready         = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid          <= 1'b0;
      in_chan.data_byte      <= 8'h00;
      in_chan.end_of_message <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        scan_byte(in_chan.data_byte, in_chan.end_of_message);
        bytes_to_send.delete(0);
        bytes_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (bytes_to_send.size() > 0 &&
            ((bytes_taken >= 450 && bytes_taken < 750) || $urandom_range(0, 99) >= 35)) begin
          in_chan.valid          <= 1'b1;
          in_chan.data_byte      <= bytes_to_send[0].data;
          in_chan.end_of_message <= bytes_to_send[0].last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          $error("result with nothing expected: well_formed %0b pure_ascii %0b",
                 out_chan.well_formed, out_chan.pure_ascii);
          fail_count++;
        end else begin
          got = verdicts_due.pop_front();
          if (out_chan.well_formed !== got.well_formed) begin
            $error("well_formed: expected %0b, actual %0b", got.well_formed,
                   out_chan.well_formed);
            fail_count++;
          end
          if (out_chan.pure_ascii !== got.pure_ascii) begin
            $error("pure_ascii: expected %0b, actual %0b", got.pure_ascii,
                   out_chan.pure_ascii);
            fail_count++;
          end
        end
        if (results_seen == 40 || results_seen == 110) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= (results_seen >= 55 && results_seen < 95) ||
                          $urandom_range(0, 99) >= 35;
      end
    end
  end

  initial begin
    fail_count   = 0;
    bytes_taken  = 0;
    results_seen = 0;
    hold_left    = 0;
    clear_decoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // printable edges and whitespace
    msg_bytes = '{PRINT_LO, PRINT_HI, BYTE_TAB, BYTE_LF, BYTE_CR};
    queue_message();
    // other control byte, delete
    msg_bytes = '{8'h01};
    queue_message();
    msg_bytes = '{8'h7F};
    queue_message();
    // zero lead stops checking, trailing junk ignored
    msg_bytes = '{LEAD2_LO, CONT_LO, BYTE_NUL, 8'hFF};
    queue_message();
    // overlong, surrogate, above max
    msg_bytes = '{LEAD3_E0, CONT_9F, CONT_LO};
    queue_message();
    msg_bytes = '{LEAD3_ED, CONT_A0, CONT_LO};
    queue_message();
    msg_bytes = '{LEAD4_F4, CONT_90};
    queue_message();
    // sequence cut by end of message
    msg_bytes = '{LEAD4_F0, CONT_90, CONT_LO};
    queue_message();
    // zero in continuation position
    msg_bytes = '{LEAD3_LO, BYTE_NUL};
    queue_message();
    msg_bytes = '{8'hFF};
    queue_message();
    wait_drained();

    random_messages(500);
    wait_drained();
    random_messages(560);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
